// File: hdl/pttc_pkg.sv
// types, constants and base decoding shared by the pairwise transition / transversion counter
package pttc_pkg;

	localparam int BYTE_W      = 8;
	localparam int CNT_W       = 16;
	localparam int IDX_FIELD_W = 3;
	localparam int ACT_W       = 4;
	localparam int COL_W       = 64;

	localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	localparam logic [BYTE_W-1:0] CHR_A = 8'h61;
	localparam logic [BYTE_W-1:0] CHR_C = 8'h63;
	localparam logic [BYTE_W-1:0] CHR_G = 8'h67;
	localparam logic [BYTE_W-1:0] CHR_T = 8'h74;

	// bit 1 set for pyrimidines, so a transition keeps bit 1
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_G = 2'd1;
	localparam logic [1:0] BASE_C = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef struct packed {
		logic [COL_W-1:0] column_bytes;
		logic             last_column;
	} col_t;

	typedef struct packed {
		logic [IDX_FIELD_W-1:0] first_index;
		logic [IDX_FIELD_W-1:0] second_index;
		logic [CNT_W-1:0]       transition_count;
		logic [CNT_W-1:0]       transversion_count;
		logic [CNT_W-1:0]       common_count;
		logic                   last_result;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] code;
	} base_t;

	typedef struct packed {
		logic [CNT_W-1:0] ts;
		logic [CNT_W-1:0] tv;
		logic [CNT_W-1:0] cm;
	} counts_t;

	typedef struct packed {
		logic             accept;
		logic             last;
		logic [ACT_W-1:0] n;
	} ctrl_t;

	function automatic base_t decode_base(input logic [BYTE_W-1:0] b);
		base_t r;
		r.ok   = 1'b1;
		r.code = BASE_A;
		unique case (b)
			CHR_A: r.code = BASE_A;
			CHR_G: r.code = BASE_G;
			CHR_C: r.code = BASE_C;
			CHR_T: r.code = BASE_T;
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_W'(1);
	endfunction

endpackage

// File: hdl/pairwise_transition_transversion_count.sv
// top level of the pairwise transition / transversion counter
//
// one input transaction carries one alignment column: a byte per sequence and a
// last-column flag. every active pair i<j has its own counter lane, so a column
// is taken every cycle with no gaps while it is not the last one.
// the last column is counted, all pair counts are copied to snapshot registers
// and the live counters cleared in the same cycle, so the next run may start at
// once. the snapshots are then sent as one result transaction per pair i<=j in
// row order, one per cycle while out_stall is low, each loaded through the result register;
// with n active sequences that is n*(n+1)/2 results (36 at most), paced by the
// single result register. columns of the next run are accepted during that walk;
// only a further last column is held by in_stall until the walk has loaded its
// final result. out_stall holds the result register and the walk behind it.
// cfg_we writes active_sequences; write it only while the block is idle.
// reset clears all counters, sets active_sequences to 8 and empties the output.
module pairwise_transition_transversion_count #(
	parameter int MAX_SEQUENCES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pttc_pkg::ACT_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  pttc_pkg::col_t                in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output pttc_pkg::res_t                out_data
);
	import pttc_pkg::*;

	logic [ACT_W-1:0] active_q;
	logic [ACT_W-1:0] n_eff;
	logic             accept;
	logic             busy;
	ctrl_t            ctrl;
	base_t            bases [MAX_SEQUENCES];
	counts_t          snaps [MAX_SEQUENCES][MAX_SEQUENCES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	assign n_eff    = (active_q > ACT_W'(MAX_SEQUENCES)) ? ACT_W'(MAX_SEQUENCES) : active_q;
	assign in_stall = busy & in_data.last_column;
	assign accept   = in_valid & !in_stall;

	assign ctrl.accept = accept;
	assign ctrl.last   = in_data.last_column;
	assign ctrl.n      = n_eff;

	for (genvar gs = 0; gs < MAX_SEQUENCES; gs++) begin : g_base
		assign bases[gs] = decode_base(in_data.column_bytes[BYTE_W*gs +: BYTE_W]);
	end

	for (genvar gi = 0; gi < MAX_SEQUENCES; gi++) begin : g_row
		for (genvar gj = 0; gj < MAX_SEQUENCES; gj++) begin : g_col
			if (gj > gi) begin : g_lane
				pttc_pair_lane u_lane (
					.clk    (clk),
					.arst_n (arst_n),
					.accept (accept),
					.last   (in_data.last_column),
					.en     (ACT_W'(gj) < n_eff),
					.x      (bases[gi]),
					.y      (bases[gj]),
					.snap   (snaps[gi][gj])
				);
			end else begin : g_none
				assign snaps[gi][gj] = '0;
			end
		end
	end

	pttc_merge #(
		.MAX_SEQUENCES (MAX_SEQUENCES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.snaps     (snaps),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: hdl/pttc_pair_lane.sv
// counters and emission snapshot for one sequence pair
module pttc_pair_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              last,
	input  logic              en,
	input  pttc_pkg::base_t   x,
	input  pttc_pkg::base_t   y,
	output pttc_pkg::counts_t snap
);
	import pttc_pkg::*;

	counts_t cnt_q;
	counts_t snap_q;
	counts_t nxt;
	logic    hit;
	logic    differ;
	logic    same_class;

	assign hit        = en & x.ok & y.ok;
	assign differ     = x.code != y.code;
	assign same_class = x.code[1] == y.code[1];

	always_comb begin
		nxt = cnt_q;
		if (hit) begin
			nxt.cm = sat_inc(cnt_q.cm);
			if (differ && same_class)
				nxt.ts = sat_inc(cnt_q.ts);
			if (differ && !same_class)
				nxt.tv = sat_inc(cnt_q.tv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= last ? '0 : nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last)
			snap_q <= nxt;
	end

	assign snap = snap_q;

endmodule

// File: hdl/pttc_merge.sv
// column counter and sequencer that walks the pair snapshots into the result register
module pttc_merge #(
	parameter int MAX_SEQUENCES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pttc_pkg::ctrl_t   ctrl,
	input  pttc_pkg::counts_t snaps [MAX_SEQUENCES][MAX_SEQUENCES],
	output logic              busy,
	output logic              out_valid,
	input  logic              out_stall,
	output pttc_pkg::res_t    out_data
);
	import pttc_pkg::*;

	localparam int IDX_W = $clog2(MAX_SEQUENCES);

	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] col_snap_q;
	logic [CNT_W-1:0] col_nxt;
	logic             busy_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [ACT_W-1:0] n_q;
	logic             ov_q;
	res_t             res_q;
	logic             load;
	logic             row_end;
	logic             final_pair;
	counts_t          sel;
	res_t             res_nxt;

	assign col_nxt    = sat_inc(col_q);
	assign load       = !ov_q || !out_stall;
	assign row_end    = ACT_W'(j_q) == n_q - ACT_W'(1);
	assign final_pair = ACT_W'(i_q) == n_q - ACT_W'(1);
	assign sel        = snaps[i_q][j_q];

	always_comb begin
		res_nxt.first_index  = IDX_FIELD_W'(i_q);
		res_nxt.second_index = IDX_FIELD_W'(j_q);
		res_nxt.last_result  = final_pair;
		if (i_q == j_q) begin
			res_nxt.transition_count   = '0;
			res_nxt.transversion_count = '0;
			res_nxt.common_count       = col_snap_q;
		end else begin
			res_nxt.transition_count   = sel.ts;
			res_nxt.transversion_count = sel.tv;
			res_nxt.common_count       = sel.cm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
			n_q    <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (ctrl.accept)
				col_q <= ctrl.last ? '0 : col_nxt;
			if (ctrl.accept && ctrl.last && ctrl.n != '0) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				j_q    <= '0;
				n_q    <= ctrl.n;
			end else if (busy_q && load) begin
				if (final_pair) begin
					busy_q <= 1'b0;
				end else if (row_end) begin
					i_q <= i_q + IDX_W'(1);
					j_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end
			if (load)
				ov_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept && ctrl.last)
			col_snap_q <= col_nxt;
		if (busy_q && load)
			res_q <= res_nxt;
	end

	assign busy      = busy_q;
	assign out_valid = ov_q;
	assign out_data  = res_q;

endmodule
